### rtl/core/hhwf_pkg.sv
package hhwf_pkg;

    localparam int POS_W    = 32;
    localparam int LEN_W    = 31;
    localparam int IDX_W    = 20;
    localparam int FORCE_W  = 32;
    localparam int ENERGY_W = 48;
    localparam int DIFF_W   = 32;   // magnitude of a coordinate difference
    localparam int DIST_W   = 33;   // |r| fits 33 bits
    localparam int SUMSQ_W  = 66;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 66;

    localparam int S_TDATA_W = 296;
    localparam int M_TDATA_W = 184;

    // s_tdata field offsets
    localparam int S_AX_LSB   = 0;
    localparam int S_AY_LSB   = 32;
    localparam int S_AZ_LSB   = 64;
    localparam int S_BX_LSB   = 96;
    localparam int S_BY_LSB   = 128;
    localparam int S_BZ_LSB   = 160;
    localparam int S_D0_LSB   = 192;
    localparam int S_K_LSB    = 223;
    localparam int S_IA_LSB   = 254;
    localparam int S_IB_LSB   = 274;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [FORCE_W:0]    NEG_LIMIT  = 33'h0_8000_0000;
    localparam logic [FORCE_W:0]    POS_LIMIT  = 33'h0_7FFF_FFFF;

endpackage

### rtl/core/half_harmonic_wall_force.sv
// Half-harmonic wall restraint, one term per transaction. The sum of squares and
// the stiffness, energy and force products share one 33x33 multiplier under the
// sequencer; the 33-step bit-serial square root and the three (FRAC_BITS+1)-step
// restoring divisions each use their own subtract/compare logic.
// s_tready is low from acceptance until the result is loaded into the output
// register, and rises as that load is made, so the next term can then be taken.
// The load waits while a previous result is still held in that register. A
// finished result waits in that register while the next term is already accepted.
// Energy is accumulated only when energy_enable is set, and is reported and
// cleared on the tlast term.
module half_harmonic_wall_force_core #(
    parameter int FRAC_BITS   = 16,
    parameter int INDEX_WIDTH = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,   // energy_enable
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, rest_length,
    // stiffness, atom_a_index, atom_b_index, zero pad
    input  logic [hhwf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,       // push_inward
    input  logic                             s_tlast,       // term_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // force_atom_a, force_atom_b, force_x, force_y, force_z, energy_total
    output logic [hhwf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,       // term_active
    output logic                             m_tlast        // result_last
);

    localparam int M_W   = 64 - FRAC_BITS;          // k*|e| >> F
    localparam int U_W   = FRAC_BITS + 1;           // unit vector component
    localparam int EP_W  = M_W + hhwf_pkg::DIST_W;  // m*|e|
    localparam int CNT_W = 6;
    localparam logic [hhwf_pkg::IDX_W-1:0] IDX_MASK =
        (INDEX_WIDTH >= hhwf_pkg::IDX_W) ? '1
        : hhwf_pkg::IDX_W'((64'd1 << INDEX_WIDTH) - 64'd1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(32);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_EVAL, ST_M_MUL, ST_M_ACC,
        ST_E_LO, ST_E_LO_ACC, ST_E_HI, ST_E_HI_ACC, ST_E_ADD,
        ST_DIV, ST_F_LO, ST_F_LO_ACC, ST_F_HI, ST_F_ACC, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic en_reg, en_next;
    logic [hhwf_pkg::ENERGY_W-1:0] acc_reg, acc_next;
    logic [hhwf_pkg::DIFF_W-1:0] mag_reg [3];
    logic [hhwf_pkg::DIFF_W-1:0] mag_next [3];
    logic [2:0] negd_reg, negd_next;
    logic [hhwf_pkg::LEN_W-1:0] d0_reg, d0_next, k_reg, k_next;
    logic push_reg, push_next, last_reg, last_next;
    logic [hhwf_pkg::IDX_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [hhwf_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [hhwf_pkg::SUMSQ_W-1:0] sumsq_reg, sumsq_next;
    logic [33:0] root_reg, root_next;
    logic [35:0] srem_reg, srem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic [hhwf_pkg::DIST_W-1:0] emag_reg, emag_next;
    logic eneg_reg, eneg_next, active_reg, active_next;
    logic [M_W-1:0] m_reg, m_next;
    logic [EP_W-1:0] eprod_reg, eprod_next;
    logic [33:0] rem_reg, rem_next;
    logic [U_W-1:0] q_reg, q_next;
    logic [hhwf_pkg::PROD_W-1:0] fprod_reg, fprod_next;
    logic [hhwf_pkg::FORCE_W-1:0] force_reg [3];
    logic [hhwf_pkg::FORCE_W-1:0] force_next [3];
    logic m_valid_reg, m_valid_next, m_user_reg, m_user_next, m_last_reg, m_last_next;
    logic [hhwf_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // datapath temporaries
    logic [hhwf_pkg::MUL_W-1:0] mul_a, mul_b;
    logic [hhwf_pkg::PROD_W-1:0] mul_p;
    logic [hhwf_pkg::DIST_W-1:0] sep_len;
    logic [32:0] diff [3];
    logic [35:0] s_remt, s_trial;
    logic signed [34:0] e_val;
    logic [33:0] d_r;
    logic d_ge;
    logic [hhwf_pkg::PROD_W-1:0] f_sum, f_sh;
    logic [hhwf_pkg::FORCE_W:0] f_mag;
    logic f_neg;
    logic [63:0] e_sh;
    logic [hhwf_pkg::ENERGY_W-1:0] e_term;
    logic [hhwf_pkg::ENERGY_W:0] e_sum;
    logic go_force;

    assign sep_len = root_reg[hhwf_pkg::DIST_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = {1'b0, mag_reg[comp_reg]};
                mul_b = {1'b0, mag_reg[comp_reg]};
            end
            ST_M_MUL:
            begin
                mul_a = emag_reg;
                mul_b = {2'b0, k_reg};
            end
            ST_E_LO:
            begin
                mul_a = {1'b0, m_reg[31:0]};
                mul_b = emag_reg;
            end
            ST_E_HI:
            begin
                mul_a = hhwf_pkg::MUL_W'(m_reg[M_W-1:32]);
                mul_b = emag_reg;
            end
            ST_F_LO:
            begin
                mul_a = {1'b0, m_reg[31:0]};
                mul_b = hhwf_pkg::MUL_W'(q_reg);
            end
            ST_F_HI:
            begin
                mul_a = hhwf_pkg::MUL_W'(m_reg[M_W-1:32]);
                mul_b = hhwf_pkg::MUL_W'(q_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {33'b0, mul_a} * {33'b0, mul_b};

    always_comb
    begin
        diff[0] = 33'($signed(s_tdata[hhwf_pkg::S_AX_LSB +: 32]))
                - 33'($signed(s_tdata[hhwf_pkg::S_BX_LSB +: 32]));
        diff[1] = 33'($signed(s_tdata[hhwf_pkg::S_AY_LSB +: 32]))
                - 33'($signed(s_tdata[hhwf_pkg::S_BY_LSB +: 32]));
        diff[2] = 33'($signed(s_tdata[hhwf_pkg::S_AZ_LSB +: 32]))
                - 33'($signed(s_tdata[hhwf_pkg::S_BZ_LSB +: 32]));

        // one root digit per cycle
        s_remt  = {srem_reg[33:0], sumsq_reg[65:64]};
        s_trial = {root_reg, 2'b01};

        e_val = $signed({2'b0, sep_len}) - $signed({4'b0, d0_reg});

        // one quotient bit per cycle
        d_ge = rem_reg >= {1'b0, sep_len};
        d_r  = d_ge ? (rem_reg - {1'b0, sep_len}) : rem_reg;

        f_sum = fprod_reg + {prod_reg[33:0], 32'b0};
        f_sh  = f_sum >> FRAC_BITS;
        f_neg = eneg_reg != negd_reg[comp_reg];
        if (f_neg)
            f_mag = (f_sh > 66'(hhwf_pkg::NEG_LIMIT)) ? hhwf_pkg::NEG_LIMIT : f_sh[32:0];
        else
            f_mag = (f_sh > 66'(hhwf_pkg::POS_LIMIT)) ? hhwf_pkg::POS_LIMIT : f_sh[32:0];

        e_sh = eprod_reg[63:0] >> (FRAC_BITS + 1);
        if ((|eprod_reg[EP_W-1:64]) || (e_sh > 64'(hhwf_pkg::ENERGY_MAX)))
            e_term = hhwf_pkg::ENERGY_MAX;
        else
            e_term = e_sh[hhwf_pkg::ENERGY_W-1:0];
        e_sum = {1'b0, acc_reg} + {1'b0, e_term};
    end

    always_comb
    begin
        state_next   = state_reg;
        en_next      = cfg_wr_en ? cfg_wr_data : en_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        negd_next    = negd_reg;
        d0_next      = d0_reg;
        k_next       = k_reg;
        push_next    = push_reg;
        last_next    = last_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        prod_next    = prod_reg;
        sumsq_next   = sumsq_reg;
        root_next    = root_reg;
        srem_next    = srem_reg;
        cnt_next     = cnt_reg;
        comp_next    = comp_reg;
        emag_next    = emag_reg;
        eneg_next    = eneg_reg;
        active_next  = active_reg;
        m_next       = m_reg;
        eprod_next   = eprod_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        fprod_next   = fprod_reg;
        force_next   = force_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        m_data_next  = m_data_reg;
        go_force     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        negd_next[c] = diff[c][32];
                        mag_next[c]  = diff[c][32] ? 32'(-diff[c]) : diff[c][31:0];
                    end
                    d0_next    = s_tdata[hhwf_pkg::S_D0_LSB +: hhwf_pkg::LEN_W];
                    k_next     = s_tdata[hhwf_pkg::S_K_LSB +: hhwf_pkg::LEN_W];
                    ia_next    = s_tdata[hhwf_pkg::S_IA_LSB +: hhwf_pkg::IDX_W] & IDX_MASK;
                    ib_next    = s_tdata[hhwf_pkg::S_IB_LSB +: hhwf_pkg::IDX_W] & IDX_MASK;
                    push_next  = s_tuser;
                    last_next  = s_tlast;
                    comp_next  = '0;
                    sumsq_next = '0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                sumsq_next = sumsq_reg + prod_reg;
                if (comp_reg == 2'd2)
                begin
                    cnt_next   = '0;
                    root_next  = '0;
                    srem_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQRT:
            begin
                sumsq_next = {sumsq_reg[63:0], 2'b00};
                if (s_remt >= s_trial)
                begin
                    srem_next = s_remt - s_trial;
                    root_next = {root_reg[32:0], 1'b1};
                end
                else
                begin
                    srem_next = s_remt;
                    root_next = {root_reg[32:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                eneg_next   = e_val[34];
                emag_next   = e_val[34] ? 33'(-e_val) : e_val[32:0];
                active_next = push_reg ? e_val[34] : (!e_val[34] && (e_val != '0));
                for (int c = 0; c < 3; c++)
                    force_next[c] = '0;
                if (active_next)
                    state_next = ST_M_MUL;
                else
                    state_next = ST_FINISH;
            end
            ST_M_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_M_ACC;
            end
            ST_M_ACC:
            begin
                m_next = prod_reg[63:FRAC_BITS];
                if (en_reg)
                    state_next = ST_E_LO;
                else
                    go_force = 1'b1;
            end
            ST_E_LO:
            begin
                prod_next  = mul_p;
                state_next = ST_E_LO_ACC;
            end
            ST_E_LO_ACC:
            begin
                eprod_next = EP_W'(prod_reg);
                state_next = ST_E_HI;
            end
            ST_E_HI:
            begin
                prod_next  = mul_p;
                state_next = ST_E_HI_ACC;
            end
            ST_E_HI_ACC:
            begin
                eprod_next = eprod_reg + (EP_W'(prod_reg) << 32);
                state_next = ST_E_ADD;
            end
            ST_E_ADD:
            begin
                acc_next = e_sum[hhwf_pkg::ENERGY_W] ? hhwf_pkg::ENERGY_MAX
                         : e_sum[hhwf_pkg::ENERGY_W-1:0];
                go_force = 1'b1;
            end
            ST_DIV:
            begin
                rem_next = {d_r[32:0], 1'b0};
                q_next   = {q_reg[U_W-2:0], d_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                    state_next = ST_F_LO;
            end
            ST_F_LO:
            begin
                prod_next  = mul_p;
                state_next = ST_F_LO_ACC;
            end
            ST_F_LO_ACC:
            begin
                fprod_next = prod_reg;
                state_next = ST_F_HI;
            end
            ST_F_HI:
            begin
                prod_next  = mul_p;
                state_next = ST_F_ACC;
            end
            ST_F_ACC:
            begin
                force_next[comp_reg] = f_neg ? 32'(-f_mag) : f_mag[31:0];
                if (comp_reg == 2'd2)
                    state_next = ST_FINISH;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    rem_next   = {2'b0, mag_reg[comp_reg + 2'd1]};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = active_reg;
                    m_last_next  = last_reg;
                    m_data_next  = {(last_reg && en_reg) ? acc_reg
                                                         : {hhwf_pkg::ENERGY_W{1'b0}},
                                    force_reg[2], force_reg[1], force_reg[0],
                                    ib_reg, ia_reg};
                    if (last_reg)
                        acc_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // direction undefined at zero separation: forces stay zero
        if (go_force)
        begin
            if (sep_len == '0)
                state_next = ST_FINISH;
            else
            begin
                comp_next  = '0;
                rem_next   = {2'b0, mag_reg[0]};
                cnt_next   = '0;
                state_next = ST_DIV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            en_reg      <= 1'b1;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_user_reg  <= 1'b0;
            m_last_reg  <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            en_reg      <= en_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            m_user_reg  <= m_user_next;
            m_last_reg  <= m_last_next;
            m_data_reg  <= m_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        negd_reg   <= negd_next;
        d0_reg     <= d0_next;
        k_reg      <= k_next;
        push_reg   <= push_next;
        last_reg   <= last_next;
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        prod_reg   <= prod_next;
        sumsq_reg  <= sumsq_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        cnt_reg    <= cnt_next;
        comp_reg   <= comp_next;
        emag_reg   <= emag_next;
        eneg_reg   <= eneg_next;
        active_reg <= active_next;
        m_reg      <= m_next;
        eprod_reg  <= eprod_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        fprod_reg  <= fprod_next;
        force_reg  <= force_next;
    end

    // one term in flight: a new transaction is never taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a term is in progress");

    // inactive term carries no force
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[135:40] == '0))
        else $error("nonzero force on inactive term");

    // energy reported only on the last term
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[183:136] == '0))
        else $error("energy reported before last term");

    // accumulator is empty after a last term is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE && last_reg) |=> (acc_reg == '0))
        else $error("energy accumulator not cleared");

endmodule
